// ----- hw/rtl/kvlt_pkg.sv -----
package kvlt_pkg;

   localparam int POS_BITS  = 16;
   localparam int BYTE_BITS = 8;
   localparam int OUT_BITS  = 16;

   typedef logic [POS_BITS-1:0]  pos_type;
   typedef logic [BYTE_BITS-1:0] byte_type;
   typedef logic [OUT_BITS-1:0]  out_type;

   localparam pos_type POS_MAX = {POS_BITS{1'b1}};

   localparam byte_type CHAR_NUL   = 8'h00;
   localparam byte_type CHAR_TAB   = 8'h09;
   localparam byte_type CHAR_LF    = 8'h0A;
   localparam byte_type CHAR_SPACE = 8'h20;
   localparam byte_type CHAR_HASH  = 8'h23;

   // offsets and lengths leave the block at the fixed output width
   function automatic out_type to_out(input pos_type value);
      return out_type'(value);
   endfunction

endpackage

// ----- hw/rtl/kvlt_req_if.sv -----
interface kvlt_req_if;
   logic                valid;
   logic                ready;
   kvlt_pkg::byte_type  text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

// ----- hw/rtl/kvlt_rsp_if.sv -----
interface kvlt_rsp_if;
   logic               valid;
   logic               ready;
   kvlt_pkg::out_type  key_start;
   kvlt_pkg::out_type  key_length;
   kvlt_pkg::out_type  value_start;
   kvlt_pkg::out_type  value_length;

   modport source (output valid, output key_start, output key_length,
                   output value_start, output value_length, input ready);
   modport sink   (input valid, input key_start, input key_length,
                   input value_start, input value_length, output ready);
endinterface

// ----- hw/rtl/key_value_line_tokenizer.sv -----
// key/value line tokenizer
// req_chan: one text byte per item, valid/ready; a zero byte ends the text
// rsp_chan: one item per completed key/value pair, giving key and value
//   offsets and lengths within the text; bytes that complete no pair give
//   no item
// path: a taken byte enters the input register, is decoded there, and a
//   pair it completes is written to the result register that drives rsp_chan
// throughput: one byte per cycle while no held result blocks a byte that
//   emits a pair; the flag and offset update sits between the two registers
// stall: a held result blocks only a byte that would emit another pair;
//   bytes that emit nothing keep flowing past it, and req_chan.ready drops
//   only when the input register holds such a blocked byte
// reset: synchronous, active high; clears both registers' valid bits and
//   the tokenizer state (line start set, no key held, position zero)
// end of text: after the zero byte all tokenizer state returns to its reset value
module key_value_line_tokenizer (
   input  logic        clock,
   input  logic        reset,
   kvlt_req_if.sink    req_chan,
   kvlt_rsp_if.source  rsp_chan
);

   // input register
   logic                in_valid_ff, in_valid_in;
   kvlt_pkg::byte_type  in_byte_ff, in_byte_in;

   // tokenizer state
   logic              in_word_ff, in_word_in;
   logic              in_comment_ff, in_comment_in;
   logic              line_start_ff, line_start_in;
   logic              key_held_ff, key_held_in;
   kvlt_pkg::pos_type word_begin_ff, word_begin_in;
   kvlt_pkg::pos_type key_start_ff, key_start_in;
   kvlt_pkg::pos_type key_length_ff, key_length_in;
   kvlt_pkg::pos_type position_ff, position_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   kvlt_pkg::out_type out_key_start_ff, out_key_start_in;
   kvlt_pkg::out_type out_key_length_ff, out_key_length_in;
   kvlt_pkg::out_type out_value_start_ff, out_value_start_in;
   kvlt_pkg::out_type out_value_length_ff, out_value_length_in;

   logic              is_end, is_newline, is_blank, is_hash;
   logic              close_word, emit, advance;
   kvlt_pkg::pos_type word_length;

   // character classes of the byte in the input register
   assign is_end     = (in_byte_ff == kvlt_pkg::CHAR_NUL);
   assign is_newline = (in_byte_ff == kvlt_pkg::CHAR_LF) || is_end;
   assign is_blank   = (in_byte_ff == kvlt_pkg::CHAR_SPACE) ||
                       (in_byte_ff == kvlt_pkg::CHAR_TAB);
   assign is_hash    = (in_byte_ff == kvlt_pkg::CHAR_HASH);

   // newline or end closes any open word; blanks close only the key word
   assign close_word  = in_word_ff && (is_newline || (is_blank && !key_held_ff));
   assign emit        = close_word && key_held_ff;
   assign word_length = position_ff - word_begin_ff;

   // a byte that emits nothing never waits on the result register
   assign advance = in_valid_ff && (!emit || !out_valid_ff || rsp_chan.ready);

   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_byte_in  = req_chan.text_byte;
      end
   end

   // per-byte state update
   always_comb begin
      in_word_in    = in_word_ff;
      in_comment_in = in_comment_ff;
      line_start_in = line_start_ff;
      key_held_in   = key_held_ff;
      word_begin_in = word_begin_ff;
      key_start_in  = key_start_ff;
      key_length_in = key_length_ff;
      position_in   = position_ff;

      if (advance) begin
         if (is_newline) begin
            in_word_in    = 1'b0;
            in_comment_in = 1'b0;
            line_start_in = 1'b1;
         end else if (is_blank) begin
            if (!key_held_ff) begin
               in_word_in = 1'b0;
            end
         end else if (is_hash && line_start_ff) begin
            // comment only when '#' is the first non-blank of the line
            in_comment_in = 1'b1;
            line_start_in = 1'b0;
         end else if (!in_comment_ff && !in_word_ff) begin
            in_word_in    = 1'b1;
            line_start_in = 1'b0;
            word_begin_in = position_ff;
         end

         if (close_word) begin
            if (!key_held_ff) begin
               key_start_in  = word_begin_ff;
               key_length_in = word_length;
               key_held_in   = 1'b1;
            end else begin
               key_held_in = 1'b0;
            end
         end

         // position saturates at its top value
         if (position_ff != kvlt_pkg::POS_MAX) begin
            position_in = position_ff + kvlt_pkg::pos_type'(1);
         end

         // end of text: back to the reset state for the next text
         if (is_end) begin
            in_word_in    = 1'b0;
            in_comment_in = 1'b0;
            line_start_in = 1'b1;
            key_held_in   = 1'b0;
            word_begin_in = '0;
            key_start_in  = '0;
            key_length_in = '0;
            position_in   = '0;
         end
      end
   end

   // result register
   always_comb begin
      out_valid_in        = out_valid_ff;
      out_key_start_in    = out_key_start_ff;
      out_key_length_in   = out_key_length_ff;
      out_value_start_in  = out_value_start_ff;
      out_value_length_in = out_value_length_ff;

      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && emit) begin
         out_valid_in        = 1'b1;
         out_key_start_in    = kvlt_pkg::to_out(key_start_ff);
         out_key_length_in   = kvlt_pkg::to_out(key_length_ff);
         out_value_start_in  = kvlt_pkg::to_out(word_begin_ff);
         out_value_length_in = kvlt_pkg::to_out(word_length);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         in_word_ff    <= 1'b0;
         in_comment_ff <= 1'b0;
         line_start_ff <= 1'b1;
         key_held_ff   <= 1'b0;
         word_begin_ff <= '0;
         key_start_ff  <= '0;
         key_length_ff <= '0;
         position_ff   <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         in_word_ff    <= in_word_in;
         in_comment_ff <= in_comment_in;
         line_start_ff <= line_start_in;
         key_held_ff   <= key_held_in;
         word_begin_ff <= word_begin_in;
         key_start_ff  <= key_start_in;
         key_length_ff <= key_length_in;
         position_ff   <= position_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_byte_ff          <= in_byte_in;
      out_key_start_ff    <= out_key_start_in;
      out_key_length_ff   <= out_key_length_in;
      out_value_start_ff  <= out_value_start_in;
      out_value_length_ff <= out_value_length_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.key_start    = out_key_start_ff;
   assign rsp_chan.key_length   = out_key_length_ff;
   assign rsp_chan.value_start  = out_value_start_ff;
   assign rsp_chan.value_length = out_value_length_ff;

endmodule

// ----- verif/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // no-acceptance limit: covers the long receiver hold plus bursts
   localparam int STUCK_LIMIT   = 5000;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_ITEMS  = 1400;
   localparam int QUIET_TAIL    = 200;
   localparam int HOLD_AT       = 800;
   localparam int MAX_REPORTS   = 10;
   localparam int SETTLE_CYCLES = 20;

   typedef struct {
      kvlt_pkg::byte_type text_byte;
      bit                 drain;
   } feed_entry_type;

   // one completed key/value pair as the block reports it
   typedef struct packed {
      kvlt_pkg::out_type key_start;
      kvlt_pkg::out_type key_length;
      kvlt_pkg::out_type value_start;
      kvlt_pkg::out_type value_length;
   } kv_pair_type;

   logic clock;
   logic reset;

   kvlt_req_if req_if ();
   kvlt_rsp_if rsp_if ();

   key_value_line_tokenizer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   always #5 clock = ~clock;

   feed_entry_type bytes_to_send[$];
   kv_pair_type    pairs_due[$];
   int             failures;
   int             cycle_count;
   int             stuck_cycles;

   // tokenizer state mirror
   logic              in_word;
   logic              in_comment;
   logic              line_start;
   logic              key_held;
   kvlt_pkg::pos_type word_begin;
   kvlt_pkg::pos_type key_begin;
   kvlt_pkg::pos_type key_len;
   kvlt_pkg::pos_type position;

   function automatic void clear_tokenizer();
      in_word    = 1'b0;
      in_comment = 1'b0;
      line_start = 1'b1;
      key_held   = 1'b0;
      word_begin = '0;
      key_begin  = '0;
      key_len    = '0;
      position   = '0;
   endfunction

   // advance the mirror by one accepted byte, queue the pair it completes
   function automatic void tokenize_byte(input kvlt_pkg::byte_type c);
      kvlt_pkg::pos_type pos;
      kvlt_pkg::pos_type len;
      logic              close;
      pos   = position;
      close = 1'b0;
      if (c == kvlt_pkg::CHAR_LF || c == kvlt_pkg::CHAR_NUL) begin
         close      = in_word;
         in_word    = 1'b0;
         in_comment = 1'b0;
         line_start = 1'b1;
      end else if (c == kvlt_pkg::CHAR_SPACE || c == kvlt_pkg::CHAR_TAB) begin
         // blanks only end the key; a value runs to the line end
         if (!key_held) begin
            close   = in_word;
            in_word = 1'b0;
         end
      end else if (c == kvlt_pkg::CHAR_HASH && line_start) begin
         in_comment = 1'b1;
         line_start = 1'b0;
      end else if (!in_comment && !in_word) begin
         in_word    = 1'b1;
         line_start = 1'b0;
         word_begin = pos;
      end
      if (close) begin
         len = pos - word_begin;
         if (!key_held) begin
            key_begin = word_begin;
            key_len   = len;
            key_held  = 1'b1;
         end else begin
            pairs_due.push_back('{kvlt_pkg::out_type'(key_begin),
                                  kvlt_pkg::out_type'(key_len),
                                  kvlt_pkg::out_type'(word_begin),
                                  kvlt_pkg::out_type'(len)});
            key_held = 1'b0;
         end
      end
      // position saturates at its top value
      if (pos != kvlt_pkg::POS_MAX)
         position = pos + 1'b1;
      // end of text drops any held key and restarts at offset zero
      if (c == kvlt_pkg::CHAR_NUL)
         clear_tokenizer();
   endfunction

   task automatic push_byte(input kvlt_pkg::byte_type b, input bit drain = 1'b0);
      feed_entry_type e;
      e.text_byte = b;
      e.drain     = drain;
      bytes_to_send.push_back(e);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(kvlt_pkg::byte_type'(s[i]));
   endtask

   task automatic push_blanks(input int count);
      for (int i = 0; i < count; i++)
         push_byte($urandom_range(0, 1) ? kvlt_pkg::CHAR_SPACE : kvlt_pkg::CHAR_TAB);
   endtask

   function automatic kvlt_pkg::byte_type word_byte();
      return kvlt_pkg::byte_type'($urandom_range(8'h21, 8'hFF));
   endfunction

   // stimulus: fills the feed queue, then releases reset and waits for the end
   initial begin
      int start_size;
      int random_count;
      int kind;
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.text_byte = kvlt_pkg::CHAR_NUL;
      rsp_if.ready   = 1'b0;
      failures       = 0;
      clear_tokenizer();

      // plain pair on one line
      push_text("k v\n");
      // comment behind leading blanks
      push_text("  #c x\n");
      // hash inside a word, tab separator, trailing blank kept in the value
      push_text("a#\tz \n");
      // high byte values in a key that the end of text then drops
      push_byte(8'hFF);
      push_byte(8'h80);
      push_byte(kvlt_pkg::CHAR_NUL);
      // value on a later line, closed by the end of text
      push_text("p\n\nq");
      push_byte(kvlt_pkg::CHAR_NUL);

      // random part; the first item waits until every pair has come
      push_byte(kvlt_pkg::CHAR_LF, 1'b1);
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         kind       = $urandom_range(0, 99);
         start_size = bytes_to_send.size();
         if (kind < 60) begin
            // well-formed key/value line
            push_blanks($urandom_range(0, 2));
            repeat ($urandom_range(1, 6)) push_byte(word_byte());
            push_blanks($urandom_range(1, 3));
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(0, 4) == 0)
                  push_blanks(1);
               else
                  push_byte(word_byte());
            end
            push_blanks($urandom_range(0, 2));
            push_byte(kvlt_pkg::CHAR_LF);
         end else if (kind < 70) begin
            push_blanks($urandom_range(0, 2));
            push_byte(kvlt_pkg::CHAR_HASH);
            repeat ($urandom_range(0, 6)) push_byte(word_byte());
            push_byte(kvlt_pkg::CHAR_LF);
         end else if (kind < 78) begin
            push_blanks($urandom_range(0, 3));
            push_byte(kvlt_pkg::CHAR_LF);
         end else if (kind < 83) begin
            push_byte(kvlt_pkg::CHAR_NUL, $urandom_range(0, 9) == 0);
         end else begin
            // noise over the whole byte range
            repeat ($urandom_range(1, 6))
               push_byte(kvlt_pkg::byte_type'($urandom_range(0, 255)));
         end
         random_count += bytes_to_send.size() - start_size;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (bytes_to_send.size() != 0 || pairs_due.size() != 0)
         @(posedge clock);
      // let any stray pair still in the pipeline show up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("PASS key_value_line_tokenizer");
      else
         $display("FAIL key_value_line_tokenizer");
      $finish;
   end

   // byte driver: holds an offered item until taken, idles in bursts
   int  send_gap;
   always @(posedge clock) begin : drive_bytes
      bit fire;
      bit offer;
      bit quiet;
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.text_byte <= kvlt_pkg::CHAR_NUL;
         send_gap         = 0;
      end else begin
         fire  = req_if.valid && req_if.ready;
         if (fire) begin
            tokenize_byte(req_if.text_byte);
            bytes_to_send.delete(0);
         end
         quiet = bytes_to_send.size() < QUIET_TAIL;
         if (req_if.valid && !fire) begin
            offer = 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
            offer = 1'b0;
         end else if (bytes_to_send.size() == 0) begin
            offer = 1'b0;
         end else if (bytes_to_send[0].drain && pairs_due.size() != 0) begin
            // pause until every pending pair has come back
            offer = 1'b0;
         end else if (!quiet && (cycle_count >> 7) % 3 != 0 && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 4);
            offer    = 1'b0;
         end else begin
            offer = 1'b1;
         end
         req_if.valid <= offer;
         if (offer)
            req_if.text_byte <= bytes_to_send[0].text_byte;
      end
   end

   // pair monitor: checks each taken item, stalls in bursts and once at length
   int  hold_left;
   bit  long_hold_done;
   always @(posedge clock) begin : check_pairs
      kv_pair_type got;
      kv_pair_type due;
      bit          take;
      if (reset) begin
         rsp_if.ready   <= 1'b0;
         hold_left      = 0;
         long_hold_done = 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.key_start, rsp_if.key_length,
                    rsp_if.value_start, rsp_if.value_length};
            if (pairs_due.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("unexpected pair: key %0d/%0d value %0d/%0d",
                           got.key_start, got.key_length,
                           got.value_start, got.value_length);
            end else begin
               due = pairs_due.pop_front();
               if (got.key_start !== due.key_start || got.key_length !== due.key_length ||
                   got.value_start !== due.value_start ||
                   got.value_length !== due.value_length) begin
                  failures++;
                  if (failures <= MAX_REPORTS) begin
                     $display("pair mismatch: expected key %0d/%0d value %0d/%0d",
                              due.key_start, due.key_length,
                              due.value_start, due.value_length);
                     $display("               got key %0d/%0d value %0d/%0d",
                              got.key_start, got.key_length,
                              got.value_start, got.value_length);
                  end
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if (!long_hold_done && bytes_to_send.size() <= HOLD_AT) begin
            // long hold so the block backs up into its input
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            take           = 1'b0;
         end else if (bytes_to_send.size() >= QUIET_TAIL && (cycle_count >> 6) % 4 == 1 &&
                      $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 4);
            take      = 1'b0;
         end else begin
            take = 1'b1;
         end
         rsp_if.ready <= take;
      end
   end

   // watchdog on cycles where neither channel moves an item
   always @(posedge clock) begin
      if (reset) begin
         cycle_count  <= 0;
         stuck_cycles <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stuck_cycles <= 0;
         else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAIL key_value_line_tokenizer");
            $finish;
         end else
            stuck_cycles <= stuck_cycles + 1;
      end
   end

endmodule
